>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // Field widths fixed by the interface.
  localparam int COUNT_W  = 13;
  localparam int INDEX_W  = 12;
  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // Requested operation.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes.
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_RANGE = 2'd2;

  // Block count after reset.
  localparam count_t COUNT_RESET = 13'd4096;

endpackage

`default_nettype wire

>>> rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Next-fit block allocator over a used-bit map held in a word-wide RAM.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the in_valid/in_ready channel with mode and
// block_index; each request produces exactly one result transaction on
// out_valid/out_ready carrying granted_index and status. An allocate scans
// the bitmap upward from the search hint to the block count, then from
// block 0 up to the hint, marks the first free block used and returns it.
// A free clears the bit of block_index, or reports an out-of-range status.
// The block count is written on the cfg_valid/cfg_ready channel; it is
// accepted at any time but should only change while the block is idle.
// Sequence: a free goes from acceptance through ST_FREE, which writes the
// cleared bit back, to ST_RESP; an out-of-range free goes straight to
// ST_RESP. An allocate with a nonzero count passes through ST_SCAN, which
// visits one bitmap word per cycle through the single RAM read port, and
// then ST_RESP. The word holding the hint can be visited twice.
// Requests are handled one at a time. A finished result sits in the output
// register while the next request is accepted and worked on; only when that
// next result is ready and the output is still stalled does the block wait.
// Reset: the hint goes to zero, the count to 4096, and a clearing pass
// writes zero to every bitmap word while in_ready stays low. WORD_BITS
// must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration write channel.
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bba_pkg::COUNT_W-1:0]  cfg_data,
  // Request channel.
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         mode,
  input  wire logic [bba_pkg::INDEX_W-1:0]  block_index,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [bba_pkg::INDEX_W-1:0]       granted_index,
  output logic [bba_pkg::STATUS_W-1:0]      status
);

  localparam int CW        = bba_pkg::COUNT_W;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int WIW       = CW - OFF_W;
  localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CAP_INT   = (MAX_BLOCKS > (2 ** CW) - 1) ? (2 ** CW) - 1 : MAX_BLOCKS;
  localparam logic [CW-1:0] CAP = CW'(CAP_INT);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FREE  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]           state, state_next;
  logic [AW-1:0]        clr_addr, clr_addr_next;
  logic [CW-1:0]        block_count;
  logic [CW-1:0]        hint, hint_next;
  logic [CW-1:0]        lo, lo_next;
  logic [CW-1:0]        hi, hi_next;
  logic                 phase, phase_next;
  logic [WIW-1:0]       scan_w, scan_w_next;
  bba_pkg::index_t      res_index, res_index_next;
  bba_pkg::status_t     res_status, res_status_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] rd_data;

  logic [CW-1:0]        cnt;
  logic                 in_fire;
  logic                 out_load;
  logic [CW-1:0]        req_blk;
  logic [CW-1:0]        res_blk;
  logic                 start_p1;
  logic [WIW-1:0]       start_w;
  logic [WIW-1:0]       lo_w, ew;
  logic [OFF_W-1:0]     lo_off, e_off;
  logic [CW-1:0]        e_blk;
  logic [WORD_BITS-1:0] scan_mask;
  logic [WORD_BITS-1:0] scan_free;
  logic                 scan_hit;
  logic [OFF_W-1:0]     fidx;
  logic [CW-1:0]        hit_blk;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // The configuration register is always writable.
  assign cfg_ready = 1'b1;

  // Live count, saturated to the capacity of the bitmap.
  assign cnt = (block_count > CAP) ? CAP : block_count;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == ST_RESP) && (!out_valid || out_ready);

  assign req_blk  = CW'(block_index);
  assign res_blk  = CW'(res_index);
  assign start_p1 = (hint < cnt);
  assign start_w  = start_p1 ? hint[CW-1:OFF_W] : '0;

  // Scan window for the current phase: blocks lo up to hi - 1.
  assign lo_w   = lo[CW-1:OFF_W];
  assign lo_off = lo[OFF_W-1:0];
  assign e_blk  = hi - 1'b1;
  assign ew     = e_blk[CW-1:OFF_W];
  assign e_off  = e_blk[OFF_W-1:0];

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      scan_mask[b] = ((scan_w != lo_w) || (OFF_W'(b) >= lo_off)) &&
                     ((scan_w != ew)   || (OFF_W'(b) <= e_off));
    end
  end

  assign scan_free = ~rd_data & scan_mask;
  assign scan_hit  = |scan_free;

  // Lowest free bit of the word.
  always_comb begin
    fidx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (scan_free[b]) begin
        fidx = OFF_W'(b);
      end
    end
  end

  assign hit_blk = {scan_w, fidx};

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    hint_next       = hint;
    lo_next         = lo;
    hi_next         = hi;
    phase_next      = phase;
    scan_w_next     = scan_w;
    res_index_next  = res_index;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_waddr       = AW'(scan_w);
    ram_wdata       = rd_data;
    ram_raddr       = AW'(WIW'(scan_w + 1'b1));

    unique case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = AW'(clr_addr + 1'b1);
        if (clr_addr == AW'(NUM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ram_raddr = (mode == bba_pkg::MODE_FREE) ? AW'(req_blk[CW-1:OFF_W])
                                                 : AW'(start_w);
        if (in_fire) begin
          if (mode == bba_pkg::MODE_FREE) begin
            res_index_next = block_index;
            if (req_blk < cnt) begin
              res_status_next = bba_pkg::STATUS_OK;
              state_next      = ST_FREE;
            end else begin
              res_status_next = bba_pkg::STATUS_RANGE;
              state_next      = ST_RESP;
            end
          end else if (start_p1) begin
            lo_next     = hint;
            hi_next     = cnt;
            phase_next  = 1'b0;
            scan_w_next = start_w;
            state_next  = ST_SCAN;
          end else if (cnt != '0) begin
            // Hint at or past the count: only the wrapped part is scanned.
            lo_next     = '0;
            hi_next     = cnt;
            phase_next  = 1'b1;
            scan_w_next = '0;
            state_next  = ST_SCAN;
          end else begin
            hint_next       = '0;
            res_index_next  = '0;
            res_status_next = bba_pkg::STATUS_FULL;
            state_next      = ST_RESP;
          end
        end
      end

      ST_FREE: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(res_blk[CW-1:OFF_W]);
        ram_wdata  = rd_data & ~(WORD_BITS'(1) << res_blk[OFF_W-1:0]);
        state_next = ST_RESP;
      end

      ST_SCAN: begin
        if (scan_hit) begin
          ram_we          = 1'b1;
          ram_waddr       = AW'(scan_w);
          ram_wdata       = rd_data | (WORD_BITS'(1) << fidx);
          hint_next       = hit_blk;
          res_index_next  = hit_blk[bba_pkg::INDEX_W-1:0];
          res_status_next = bba_pkg::STATUS_OK;
          state_next      = ST_RESP;
        end else if (scan_w != ew) begin
          scan_w_next = WIW'(scan_w + 1'b1);
        end else if (!phase && (hint != '0)) begin
          // Upward part exhausted: wrap to block 0 and stop below the hint.
          ram_raddr   = '0;
          lo_next     = '0;
          hi_next     = hint;
          phase_next  = 1'b1;
          scan_w_next = '0;
        end else begin
          hint_next       = '0;
          res_index_next  = '0;
          res_status_next = bba_pkg::STATUS_FULL;
          state_next      = ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      hint        <= '0;
      block_count <= bba_pkg::COUNT_RESET;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      hint     <= hint_next;
      if (cfg_valid && cfg_ready) begin
        block_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    phase      <= phase_next;
    scan_w     <= scan_w_next;
    res_index  <= res_index_next;
    res_status <= res_status_next;
    if (out_load) begin
      granted_index <= res_index;
      status        <= res_status;
    end
  end

`ifndef SYNTH
  // No request may be taken while the bitmap is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("request accepted during clearing pass");

  // The scan never runs past the last word of its window.
  a_scan_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_w <= ew))
    else $error("scan pointer beyond window");

  // A granted block was free in the word read from the bitmap.
  a_grant_was_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_hit) |-> !rd_data[fidx])
    else $error("allocated a block that was already used");

  // A full report always comes with index zero and a reset hint.
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status == bba_pkg::STATUS_FULL) |-> (res_index == '0 && hint == '0))
    else $error("full status with nonzero index or hint");
`endif

endmodule

`default_nettype wire

>>> tb/bitmap_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_tb
// Self-checking testbench for the next-fit bitmap block allocator. A shadow
// copy of the used-bit map, the search hint and the block count predicts
// every result. Directed requests cover the corner cases first. Random
// phases then follow at many block counts. Both handshakes stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int TB_BLOCKS     = 4096;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLDOFF_LEN   = 300;
  // Longest allocate scan plus a margin, used for the quiet wait at the end.
  localparam int SETTLE_CYCLES = 140;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 61;

  // One expected result transaction.
  typedef struct packed {
    index_t  granted;
    status_t status;
  } grant_t;

  // Shadow allocator plus the queue of results it has promised. Requests are
  // noted at acceptance, and results are checked in order as they leave the
  // block.
  class grant_tracker;
    bit       used_map [TB_BLOCKS];
    index_t   next_hint;
    count_t   blocks;
    grant_t   grants_due [$];
    int       errors;

    function new();
      next_hint = '0;
      blocks    = COUNT_RESET;
      errors    = 0;
      foreach (used_map[i]) used_map[i] = 1'b0;
    endfunction

    // Counts above capacity saturate to the full map.
    function int live_blocks();
      return (blocks > TB_BLOCKS) ? TB_BLOCKS : int'(blocks);
    endfunction

    function void set_count(count_t value);
      blocks = value;
    endfunction

    function void note_request(logic op, index_t idx);
      grant_t exp_grant;
      int     lim;
      int     found;
      lim   = live_blocks();
      found = -1;
      if (op == MODE_FREE) begin
        exp_grant.granted = idx;
        if (idx >= lim) begin
          exp_grant.status = STATUS_RANGE;
        end else begin
          used_map[idx]    = 1'b0;
          exp_grant.status = STATUS_OK;
        end
      end else begin
        // Next fit: scan upward from the hint, then wrap to block 0. A hint
        // at or past the count leaves the upward part empty.
        for (int i = next_hint; i < lim && found < 0; i++)
          if (!used_map[i]) found = i;
        for (int i = 0; i < lim && i < next_hint && found < 0; i++)
          if (!used_map[i]) found = i;
        if (found >= 0) begin
          used_map[found]   = 1'b1;
          next_hint         = index_t'(found);
          exp_grant.granted = index_t'(found);
          exp_grant.status  = STATUS_OK;
        end else begin
          // Memory full: nothing changes except that the hint goes back to 0.
          next_hint         = '0;
          exp_grant.granted = '0;
          exp_grant.status  = STATUS_FULL;
        end
      end
      grants_due.push_back(exp_grant);
    endfunction

    function void check_grant(index_t got_index, status_t got_status);
      grant_t exp_grant;
      if (grants_due.size() == 0) begin
        $display("%0t: result with nothing expected: index %0d status %0d",
                 $time, got_index, got_status);
        errors++;
        return;
      end
      exp_grant = grants_due.pop_front();
      if (got_index !== exp_grant.granted) begin
        $display("%0t: granted_index expected %0d, actual %0d",
                 $time, exp_grant.granted, got_index);
        errors++;
      end
      if (got_status !== exp_grant.status) begin
        $display("%0t: status expected %0d, actual %0d",
                 $time, exp_grant.status, got_status);
        errors++;
      end
    endfunction

    function int pending();
      return grants_due.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  count_t  cfg_data = '0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  logic    mode = MODE_ALLOC;
  index_t  block_index = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  index_t  granted_index;
  status_t status;

  grant_tracker book = new();

  // Set by the stimulus process only. While steady_flow is high, neither
  // side idles. Each increment of holdoff_requests asks the receiver for one
  // long stall.
  bit steady_flow = 1'b0;
  int holdoff_requests = 0;

  int cycle_count = 0;

  bitmap_block_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .block_index   (block_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_index (granted_index),
    .status        (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The watchdog allows for the clearing pass after reset, for every allocate
  // scanning the whole map, and for all of the stalls, several times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver. The handshake is sampled at the edge, before the block updates
  // its outputs. Then out_ready is chosen for the next cycle. A long stall
  // runs here and is counted in cycles, while the sender keeps offering
  // requests.
  initial begin
    int holdoff_left;
    int holdoffs_served;
    holdoff_left    = 0;
    holdoffs_served = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1)
        book.check_grant(granted_index, status);
      if (holdoff_left == 0 && holdoffs_served < holdoff_requests) begin
        holdoffs_served++;
        holdoff_left = HOLDOFF_LEN;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_flow || ($urandom_range(99) >= 14);
      end
    end
  end

  // Random idle cycles ahead of a request. Each cycle is skipped with about
  // 14 percent probability.
  task automatic sender_gaps();
    while (!steady_flow && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high on return, so a back-to-back request only changes the payload.
  task automatic send_request(logic op, index_t idx);
    sender_gaps();
    in_valid    <= 1'b1;
    mode        <= op;
    block_index <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    book.note_request(op, idx);
  endtask

  // Stops offering and waits until every promised result has arrived. Every
  // request yields exactly one result, so the block is idle after that.
  task automatic wait_for_grants();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_block_count(count_t value);
    wait_for_grants();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    book.set_count(value);
  endtask

  // Slightly more allocates than frees, so that small maps fill up and wrap
  // often. Most frees hit managed blocks. Some land right at the count or
  // anywhere in the index range.
  task automatic random_request();
    int     lim;
    int     pick;
    index_t idx;
    lim  = book.live_blocks();
    pick = $urandom_range(99);
    idx  = index_t'($urandom_range(TB_BLOCKS - 1));
    if ($urandom_range(99) < 55) begin
      send_request(MODE_ALLOC, idx);
    end else begin
      if (lim > 0 && pick < 80)
        idx = index_t'($urandom_range(lim - 1));
      else if (pick < 90 && lim < TB_BLOCKS)
        idx = index_t'(lim);
      send_request(MODE_FREE, idx);
    end
  endtask

  // Block count for a random phase. Small maps dominate because they reach
  // the full and wrap cases quickly. The extremes come at fixed phases.
  function automatic count_t phase_count(int phase);
    int pick;
    pick = $urandom_range(99);
    if (phase == 0) return count_t'(TB_BLOCKS);
    if (phase == 1) return '1;
    if (phase == 2) return count_t'(1);
    if (phase == PHASES - 1) return count_t'(TB_BLOCKS - 1);
    if (pick < 70) return count_t'($urandom_range(70, 1));
    if (pick < 85) return count_t'($urandom_range(TB_BLOCKS, 71));
    if (pick < 95) return count_t'($urandom_range(8191, TB_BLOCKS + 1));
    return '0;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The block count is still at its reset value of 4096.
    // The first request carries the top index, which an allocate ignores.
    send_request(MODE_ALLOC, index_t'(TB_BLOCKS - 1));
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, '0);
    // The hint sits on block 1, so block 0 is skipped and block 2 is taken.
    send_request(MODE_ALLOC, '0);
    // Freeing a block that is already free still reports ok.
    send_request(MODE_FREE, '0);
    send_request(MODE_FREE, index_t'(TB_BLOCKS - 1));

    // With no managed blocks, the map is full and every free is out of range.
    write_block_count('0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, '0);
    send_request(MODE_FREE, index_t'(TB_BLOCKS - 1));

    // A count above capacity saturates to the full map.
    write_block_count('1);
    send_request(MODE_FREE, index_t'(TB_BLOCKS - 1));
    send_request(MODE_ALLOC, '0);

    // Three blocks: clear them, fill them, overflow, then free one and
    // allocate it again.
    write_block_count(count_t'(3));
    send_request(MODE_FREE, index_t'(0));
    send_request(MODE_FREE, index_t'(1));
    send_request(MODE_FREE, index_t'(2));
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, index_t'(3));
    send_request(MODE_FREE, index_t'(2));
    send_request(MODE_ALLOC, '0);

    // The hint is now at block 2. Shrinking to two blocks puts it past the
    // count, so the scan has to start over at block 0.
    write_block_count(count_t'(2));
    send_request(MODE_FREE, index_t'(0));
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);

    // Random phases. The count is changed only while nothing is in flight.
    // One phase gets a long receiver stall that backs the block up. Another
    // runs with no idling at all. In a third, the sender pauses halfway
    // until every result has come back.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_block_count(phase_count(phase));
      if (phase == 3) holdoff_requests = holdoff_requests + 1;
      steady_flow = (phase == 5);
      for (int item = 0; item < PHASE_ITEMS; item++) begin
        if (phase == 7 && item == PHASE_ITEMS / 2) wait_for_grants();
        random_request();
      end
    end
    steady_flow = 1'b0;

    wait_for_grants();
    // Any stray result that arrives after this point is still caught by the
    // receiver.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (book.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
